/* design/aapo_pkg.sv */
// aapo_pkg: shared types and constants for the all-pairs box overlap block
// used by aapo_ctrl, aapo_dpath and aabb_all_pairs_overlap_top
`default_nettype none

package aapo_pkg;

   localparam int MAX_BOXES_DEF = 16;
   localparam int COORD_W       = 32;
   localparam int IDX_OUT_W     = 4;
   localparam int REQ_DATA_W    = 6 * COORD_W;
   localparam int RSP_DATA_W    = 8;

   typedef struct packed {
      logic signed [COORD_W-1:0] max_z;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_x;
   } box_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CHECK,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic store;
      logic start_check;
      logic issue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic pair_none;
      logic pair_last;
      logic pipe_busy;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

/* design/aapo_ctrl.sv */
// aapo_ctrl: sequencer for load, pair check, drain and result phases
// depends on aapo_pkg
`default_nettype none

module aapo_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   input  wire                  req_tlast,
   output logic                 req_tready,
   input  aapo_pkg::status_type status,
   output aapo_pkg::cmd_type    cmd
);

   aapo_pkg::state_type state_ff;
   aapo_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aapo_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         aapo_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.store = 1'b1;
               if (req_tlast) begin
                  cmd.start_check = 1'b1;
                  state_in        = aapo_pkg::ST_CHECK;
               end
            end
         end
         aapo_pkg::ST_CHECK: begin
            if (status.pair_none) begin
               state_in = aapo_pkg::ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
               if (status.pair_last) begin
                  state_in = aapo_pkg::ST_DRAIN;
               end
            end
         end
         aapo_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = aapo_pkg::ST_EMIT;
            end
         end
         aapo_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.out_free && status.emit_last) begin
               state_in = aapo_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = aapo_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

/* design/aapo_dpath.sv */
// aapo_dpath: box memory, pair counters, overlap compare, hit flags, result register
// depends on aapo_pkg
`default_nettype none

module aapo_dpath #(
   parameter int MAX_BOXES = aapo_pkg::MAX_BOXES_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  [aapo_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  aapo_pkg::cmd_type                    cmd,
   output aapo_pkg::status_type                 status,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [aapo_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);

   localparam int IW = $clog2(MAX_BOXES);
   localparam int CW = $clog2(MAX_BOXES + 1);

   aapo_pkg::box_type mem_ff [MAX_BOXES];
   aapo_pkg::box_type rd_a_ff;
   aapo_pkg::box_type rd_b_ff;

   logic [CW-1:0]        count_ff;
   logic                 ovf_ff;
   logic [IW-1:0]        i_ff;
   logic [IW-1:0]        j_ff;
   logic [IW-1:0]        s1_i_ff;
   logic [IW-1:0]        s1_j_ff;
   logic                 s1_vld_ff;
   logic [MAX_BOXES-1:0] hit_ff;
   logic [IW-1:0]        k_ff;

   logic                 rsp_vld_ff;
   logic [aapo_pkg::IDX_OUT_W-1:0] rsp_idx_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_last_ff;
   logic                 rsp_ovf_ff;

   logic                 room;
   logic                 j_end;
   logic                 i_end;
   logic                 k_end;
   logic                 ovl;
   logic                 out_free;
   logic                 emit_fire;

   assign room      = count_ff < CW'(MAX_BOXES);
   assign j_end     = (CW + 1)'(j_ff) + (CW + 1)'(1) == (CW + 1)'(count_ff);
   assign i_end     = (CW + 1)'(i_ff) + (CW + 1)'(2) == (CW + 1)'(count_ff);
   assign k_end     = (CW + 1)'(k_ff) + (CW + 1)'(1) == (CW + 1)'(count_ff);
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign emit_fire = cmd.emit && out_free;

   assign ovl = (rd_a_ff.min_x < rd_b_ff.max_x) && (rd_a_ff.max_x > rd_b_ff.min_x) &&
                (rd_a_ff.min_y < rd_b_ff.max_y) && (rd_a_ff.max_y > rd_b_ff.min_y) &&
                (rd_a_ff.min_z < rd_b_ff.max_z) && (rd_a_ff.max_z > rd_b_ff.min_z);

   assign status.pair_none = count_ff < CW'(2);
   assign status.pair_last = i_end && j_end;
   assign status.pipe_busy = s1_vld_ff;
   assign status.out_free  = out_free;
   assign status.emit_last = k_end;

   // box memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.store && room) begin
         mem_ff[count_ff[IW-1:0]] <= req_tdata;
      end
      if (cmd.issue) begin
         rd_a_ff <= mem_ff[i_ff];
         rd_b_ff <= mem_ff[j_ff];
         s1_i_ff <= i_ff;
         s1_j_ff <= j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         s1_vld_ff  <= 1'b0;
         hit_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         if (cmd.store) begin
            if (room) begin
               count_ff <= count_ff + CW'(1);
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.start_check) begin
            i_ff   <= '0;
            j_ff   <= IW'(1);
            k_ff   <= '0;
            hit_ff <= '0;
         end else if (cmd.issue) begin
            if (j_end) begin
               i_ff <= i_ff + IW'(1);
               j_ff <= i_ff + IW'(2);
            end else begin
               j_ff <= j_ff + IW'(1);
            end
         end
         if (s1_vld_ff && ovl) begin
            hit_ff[s1_i_ff] <= 1'b1;
            hit_ff[s1_j_ff] <= 1'b1;
         end
         if (emit_fire) begin
            rsp_vld_ff <= 1'b1;
            k_ff       <= k_ff + IW'(1);
            if (k_end) begin
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_idx_ff  <= aapo_pkg::IDX_OUT_W'(k_ff);
         rsp_hit_ff  <= hit_ff[k_ff];
         rsp_last_ff <= k_end;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(aapo_pkg::RSP_DATA_W - aapo_pkg::IDX_OUT_W - 1){1'b0}},
                        rsp_hit_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

/* design/aabb_all_pairs_overlap_top.sv */
// aabb_all_pairs_overlap_top: all-pairs strict overlap test on a set of boxes
// depends on aapo_pkg, aapo_ctrl, aapo_dpath
//
//   channel | dir | tdata                                         | tlast      | tuser
//   req_    | in  | min_x,min_y,min_z,max_x,max_y,max_z (192 b)   | last_box   | -
//   rsp_    | out | box_index[3:0], hit[4], zeros [7:5]           | last_result| overflowed
//
// loading accepts a box on every beat; the set closes on the beat with tlast
// the check runs one pair per cycle through a box memory with two registered read ports:
// N*(N-1)/2 pairs read, then compared; N results, one per cycle unless rsp_tready stalls
// req_tready is low after the closing beat until the last result sits in the output register
// reset is synchronous and clears counters, flags and the output valid
`default_nettype none

module aabb_all_pairs_overlap_top #(
   parameter int MAX_BOXES = aapo_pkg::MAX_BOXES_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // min_x, min_y, min_z, max_x, max_y, max_z
   input  wire  [aapo_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire                             req_tlast,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // box_index, hit, zero pad
   output logic [aapo_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // overflowed
   output logic                            rsp_tuser
);

   aapo_pkg::cmd_type    cmd;
   aapo_pkg::status_type status;

   aapo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aapo_dpath #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
